/* rtl/core/i2d_pkg.sv */
`timescale 1ns / 1ps

package i2d_pkg;

    // Width of the converted value; bits of the input above it are ignored
    localparam int VALUE_WIDTH = 64;

    // Decimal digits needed for the largest VALUE_WIDTH-bit value (log10(2) ~ 0.30103)
    localparam int NUM_DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BCD_WIDTH   = NUM_DIGITS * 4;

    localparam int BIT_CNT_W   = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam int DIG_CNT_W   = $clog2(NUM_DIGITS + 1);

    localparam int CHAR_WIDTH  = 6;
    localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO  = CHAR_WIDTH'(48);
    localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = CHAR_WIDTH'(45);

    // Input beat
    typedef struct packed {
        logic        op;
        logic [63:0] value;
    } i2d_req_t;

    // Output beat
    typedef struct packed {
        logic [CHAR_WIDTH-1:0] character;
        logic                  last;
    } i2d_res_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic dabble;
        logic emit_sign;
        logic emit_digit;
        logic shift_digit;
        logic last;
    } i2d_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic neg;
        logic top_zero;
    } i2d_status_t;

endpackage

/* rtl/core/i2d_datapath.sv */
`timescale 1ns / 1ps

module i2d_datapath
    import i2d_pkg::*;
(
    input  logic        clk,
    input  i2d_req_t    request,
    input  i2d_cmd_t    cmd,
    output i2d_status_t status,
    output i2d_res_t    result
);

    logic [VALUE_WIDTH-1:0] bin_reg;
    logic [VALUE_WIDTH-1:0] bin_next;
    logic [BCD_WIDTH-1:0]   bcd_reg;
    logic [BCD_WIDTH-1:0]   bcd_next;
    logic                   neg_reg;
    logic                   neg_next;
    logic [CHAR_WIDTH-1:0]  char_reg;
    logic [CHAR_WIDTH-1:0]  char_next;
    logic                   last_reg;
    logic                   last_next;

    logic [VALUE_WIDTH-1:0] masked;
    logic                   in_neg;
    logic [BCD_WIDTH-1:0]   adjusted;
    logic [3:0]             top_digit;

    assign masked    = request.value[VALUE_WIDTH-1:0];
    assign in_neg    = request.op & masked[VALUE_WIDTH-1];
    assign top_digit = bcd_reg[BCD_WIDTH-1 -: 4];

    // Add three to every BCD digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
            begin
                adjusted[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end
            else
            begin
                adjusted[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    // Select next value of the working registers
    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        neg_next  = neg_reg;
        char_next = char_reg;
        last_next = last_reg;
        if (cmd.load)
        begin
            neg_next = in_neg;
            bin_next = in_neg ? (~masked + VALUE_WIDTH'(1)) : masked;
            bcd_next = '0;
        end
        if (cmd.dabble)
        begin
            bcd_next = {adjusted[BCD_WIDTH-2:0], bin_reg[VALUE_WIDTH-1]};
            bin_next = {bin_reg[VALUE_WIDTH-2:0], 1'b0};
        end
        if (cmd.shift_digit)
        begin
            bcd_next = {bcd_reg[BCD_WIDTH-5:0], 4'd0};
        end
        if (cmd.emit_sign)
        begin
            char_next = ASCII_MINUS;
            last_next = 1'b0;
        end
        if (cmd.emit_digit)
        begin
            char_next = ASCII_ZERO + {{(CHAR_WIDTH-4){1'b0}}, top_digit};
            last_next = cmd.last;
        end
    end

    // Hold payload registers
    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign status.neg       = neg_reg;
    assign status.top_zero  = (top_digit == 4'd0);
    assign result.character = char_reg;
    assign result.last      = last_reg;

endmodule

/* rtl/core/i2d_ctrl.sv */
`timescale 1ns / 1ps

module i2d_ctrl
    import i2d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  i2d_status_t status,
    output i2d_cmd_t    cmd,
    output logic        busy,
    output logic        strobe
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SIGN,
        ST_DIGITS
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg;
    logic [BIT_CNT_W-1:0]   bit_cnt_next;
    logic [DIG_CNT_W-1:0]   dig_cnt_reg;
    logic [DIG_CNT_W-1:0]   dig_cnt_next;
    logic                   started_reg;
    logic                   started_next;
    logic                   strobe_reg;
    logic                   strobe_next;
    logic                   last_digit;

    assign last_digit = (dig_cnt_reg == DIG_CNT_W'(1));

    // Decode commands and next state
    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        started_next = started_reg;
        strobe_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load     = 1'b1;
                    bit_cnt_next = '0;
                    state_next   = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                cmd.dabble   = 1'b1;
                bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                if (bit_cnt_reg == BIT_CNT_W'(VALUE_WIDTH - 1))
                begin
                    dig_cnt_next = DIG_CNT_W'(NUM_DIGITS);
                    started_next = 1'b0;
                    state_next   = status.neg ? ST_SIGN : ST_DIGITS;
                end
            end
            ST_SIGN:
            begin
                cmd.emit_sign = 1'b1;
                strobe_next   = 1'b1;
                state_next    = ST_DIGITS;
            end
            ST_DIGITS:
            begin
                // Drop leading zeros, but always emit the final digit
                cmd.shift_digit = 1'b1;
                cmd.last        = last_digit;
                cmd.emit_digit  = started_reg | ~status.top_zero | last_digit;
                strobe_next     = cmd.emit_digit;
                started_next    = started_reg | cmd.emit_digit;
                dig_cnt_next    = dig_cnt_reg - DIG_CNT_W'(1);
                if (last_digit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, counters and the registered strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
            started_reg <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
            started_reg <= started_next;
            strobe_reg  <= strobe_next;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;

endmodule

/* rtl/core/int64_to_decimal_ascii.sv */
`timescale 1ns / 1ps

// Converts a 64-bit value (unsigned, or signed two's complement when op is set)
// to decimal ASCII text, most significant character first, one character per
// strobe beat with last marking the final one; a negative signed value gets a
// leading '-', zero gives "0". The receiver cannot stall: each character is valid on
// result in the single cycle that strobe is high. A value is accepted when
// start is high and busy is low; busy then stays high through the bit-serial
// shift-and-add-3 binary-to-BCD conversion, a sign step when negative, then
// a pass over all 20 BCD digits, in which leading zeros go without a strobe.
// The final character appears in the same cycle that busy falls, so a new
// value may be started while it is shown.
module int64_to_decimal_ascii
    import i2d_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  i2d_req_t request,
    output logic     busy,
    output logic     strobe,
    output i2d_res_t result
);

    i2d_cmd_t    cmd;
    i2d_status_t status;
    logic        ctrl_busy;

    i2d_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (ctrl_busy),
        .strobe (strobe)
    );

    i2d_datapath u_datapath (
        .clk     (clk),
        .request (request),
        .cmd     (cmd),
        .status  (status),
        .result  (result)
    );

    assign busy = ctrl_busy;

endmodule
